@@ hdl/sip_pkg.sv @@
// Shared types for the segment intersection point unit.
package sip_pkg;

   // Sideband that rides alongside each word through the divider pipeline.
   typedef struct packed {
      logic valid;
      logic hit;
      logic degenerate;
      logic neg;
   } sip_flags_type;

endpackage

@@ hdl/sip_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, magnitudes only.
module sip_divider import sip_pkg::*; #(
   parameter int N_WIDTH = 77,
   parameter int D_WIDTH = 51,
   parameter int Q_WIDTH = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  sip_flags_type       in_flags,
   input  logic [N_WIDTH-1:0]  in_num,
   input  logic [D_WIDTH-1:0]  in_den,
   output sip_flags_type       out_flags,
   output logic [Q_WIDTH-1:0]  out_quo
);

   // Quotient must fit Q_WIDTH bits: num < den * 2^Q_WIDTH.
   logic [N_WIDTH-1:0] rem_ff [Q_WIDTH-1];
   logic [D_WIDTH-1:0] den_ff [Q_WIDTH-1];
   logic [Q_WIDTH-1:0] quo_ff [Q_WIDTH];
   sip_flags_type      flg_ff [Q_WIDTH];

   genvar k;
   for (k = 0; k < Q_WIDTH; k++) begin : g_step
      logic [N_WIDTH-1:0] rem_prev;
      logic [N_WIDTH-1:0] trial;
      logic [N_WIDTH-1:0] rem_in;
      logic [D_WIDTH-1:0] den_prev;
      logic [Q_WIDTH-1:0] quo_prev;
      logic [Q_WIDTH-1:0] quo_in;
      sip_flags_type      flg_prev;
      logic               fits;

      if (k == 0) begin : g_first
         assign rem_prev = in_num;
         assign den_prev = in_den;
         assign quo_prev = '0;
         assign flg_prev = in_flags;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign flg_prev = flg_ff[k-1];
      end

      assign trial = N_WIDTH'(den_prev) << (Q_WIDTH - 1 - k);
      assign fits  = rem_prev >= trial;
      assign rem_in = fits ? rem_prev - trial : rem_prev;

      always_comb begin
         quo_in = quo_prev;
         quo_in[Q_WIDTH-1-k] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            flg_ff[k] <= '0;
         end else if (en) begin
            flg_ff[k] <= flg_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[k] <= quo_in;
         end
      end

      if (k < Q_WIDTH - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_prev;
            end
         end
      end
   end

   assign out_flags = flg_ff[Q_WIDTH-1];
   assign out_quo   = quo_ff[Q_WIDTH-1];

endmodule

@@ hdl/segment_intersection_point_unit.sv @@
// Segment intersection point unit: top level, pipelined test and point datapath.
//
//  channel  | ports                              | direction
//  ---------+------------------------------------+----------
//  request  | req_valid/req_ready, req_seg_*     | in
//  response | rsp_valid/rsp_ready, rsp_hit,      | out
//           | rsp_degenerate, rsp_cross_x/y      |
//
// One word accepted per cycle while the response side is not stalled; each
// word passes six arithmetic stages, then the bit-per-stage divider
// (COORD_WIDTH stages) and then the output register.
// Reset clears every stage valid bit; payload registers are not reset, apart from the divider's flag words.
// A stall at the response side freezes the whole pipeline in place; nothing
// is dropped or repeated, and bubbles advance when rsp_valid is low.
// The fixed-point scale cancels in N/D, so the fraction width does not
// appear in the datapath.
module segment_intersection_point_unit import sip_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_x0,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_y0,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_x1,
   input  logic signed [COORD_WIDTH-1:0] req_seg_a_y1,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_x0,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_y0,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_x1,
   input  logic signed [COORD_WIDTH-1:0] req_seg_b_y1,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic                          rsp_degenerate,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_x,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_y
);

   localparam int CW = COORD_WIDTH + 1;   // coordinate difference
   localparam int PW = 2 * CW;            // pair product
   localparam int TW = 3 * CW;            // triple product
   localparam int NW = TW + 2;            // numerator sum
   localparam int DW = PW + 1;            // denominator

   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // ---------------- stage 1: differences, bounding box ----------------
   logic                 s1_valid_ff;
   logic                 s1_box_ff;
   logic signed [CW-1:0] s1_dx1_ff, s1_dy1_ff, s1_dx2_ff, s1_dy2_ff;
   logic signed [CW-1:0] s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic signed [CW-1:0] s1_cx_ff, s1_cy_ff, s1_e2_ff;
   logic signed [CW-1:0] s1_x1_ff, s1_x3_ff, s1_y2_ff, s1_y4_ff;

   logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
   logic signed [COORD_WIDTH-1:0] amax_x, amin_x, amax_y, amin_y;
   logic signed [COORD_WIDTH-1:0] bmax_x, bmin_x, bmax_y, bmin_y;
   logic box_in;

   always_comb begin
      x1 = CW'(req_seg_a_x0);
      y1 = CW'(req_seg_a_y0);
      x2 = CW'(req_seg_a_x1);
      y2 = CW'(req_seg_a_y1);
      x3 = CW'(req_seg_b_x0);
      y3 = CW'(req_seg_b_y0);
      x4 = CW'(req_seg_b_x1);
      y4 = CW'(req_seg_b_y1);
      amax_x = (req_seg_a_x0 > req_seg_a_x1) ? req_seg_a_x0 : req_seg_a_x1;
      amin_x = (req_seg_a_x0 < req_seg_a_x1) ? req_seg_a_x0 : req_seg_a_x1;
      amax_y = (req_seg_a_y0 > req_seg_a_y1) ? req_seg_a_y0 : req_seg_a_y1;
      amin_y = (req_seg_a_y0 < req_seg_a_y1) ? req_seg_a_y0 : req_seg_a_y1;
      bmax_x = (req_seg_b_x0 > req_seg_b_x1) ? req_seg_b_x0 : req_seg_b_x1;
      bmin_x = (req_seg_b_x0 < req_seg_b_x1) ? req_seg_b_x0 : req_seg_b_x1;
      bmax_y = (req_seg_b_y0 > req_seg_b_y1) ? req_seg_b_y0 : req_seg_b_y1;
      bmin_y = (req_seg_b_y0 < req_seg_b_y1) ? req_seg_b_y0 : req_seg_b_y1;
      // touching boxes still overlap
      box_in = !(amax_x < bmin_x || amax_y < bmin_y ||
                 bmax_x < amin_x || bmax_y < amin_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_box_ff <= box_in;
         s1_dx1_ff <= x2 - x1;
         s1_dy1_ff <= y2 - y1;
         s1_dx2_ff <= x4 - x3;
         s1_dy2_ff <= y4 - y3;
         s1_ax_ff  <= x1 - x3;
         s1_ay_ff  <= y1 - y3;
         s1_bx_ff  <= x2 - x3;
         s1_by_ff  <= y2 - y3;
         s1_cx_ff  <= x4 - x1;
         s1_cy_ff  <= y4 - y1;
         s1_e2_ff  <= x4 - x2;
         s1_x1_ff  <= x1;
         s1_x3_ff  <= x3;
         s1_y2_ff  <= y2;
         s1_y4_ff  <= y4;
      end
   end

   // ---------------- stage 2: pair products ----------------
   // cross terms: [0]-[1] s1, [2]-[3] s2, [4]-[5] s3, [6]-[7] s4
   logic                 s2_valid_ff;
   logic                 s2_box_ff;
   logic signed [PW-1:0] s2_cr_ff [8];
   logic signed [PW-1:0] s2_pa_ff, s2_pb_ff, s2_pc_ff, s2_pd_ff;
   logic signed [CW-1:0] s2_e1_ff, s2_e2_ff, s2_x1_ff, s2_x3_ff, s2_y2_ff, s2_y4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_box_ff   <= s1_box_ff;
         s2_cr_ff[0] <= s1_ax_ff * s1_dy2_ff;
         s2_cr_ff[1] <= s1_ay_ff * s1_dx2_ff;
         s2_cr_ff[2] <= s1_bx_ff * s1_dy2_ff;
         s2_cr_ff[3] <= s1_by_ff * s1_dx2_ff;
         s2_cr_ff[4] <= s1_ay_ff * s1_dx1_ff;   // (x3-x1)*dy1 - (y3-y1)*dx1
         s2_cr_ff[5] <= s1_ax_ff * s1_dy1_ff;
         s2_cr_ff[6] <= s1_cx_ff * s1_dy1_ff;
         s2_cr_ff[7] <= s1_cy_ff * s1_dx1_ff;
         s2_pa_ff    <= s1_dx1_ff * s1_dx2_ff;
         s2_pb_ff    <= s1_dx1_ff * s1_dy2_ff;
         s2_pc_ff    <= s1_dx2_ff * s1_dy1_ff;
         s2_pd_ff    <= s1_dy1_ff * s1_dy2_ff;
         s2_e1_ff    <= s1_ay_ff;
         s2_e2_ff    <= s1_e2_ff;
         s2_x1_ff    <= s1_x1_ff;
         s2_x3_ff    <= s1_x3_ff;
         s2_y2_ff    <= s1_y2_ff;
         s2_y4_ff    <= s1_y4_ff;
      end
   end

   // ---------------- stage 3: straddle test, split triple products ----------------
   // Nx = T0 + T1 - T2, Ny = T3 - T4 - T5
   logic                   s3_valid_ff;
   logic                   s3_hit_ff;
   logic signed [DW-1:0]   s3_den_ff;
   logic signed [PW:0]     s3_lo_ff [6];
   logic signed [PW-1:0]   s3_hi_ff [6];

   logic signed [PW:0]     cs [4];
   logic                   cs_pos [4];
   logic                   cs_neg [4];
   logic                   straddle;
   logic signed [PW-1:0]   fac [6];
   logic signed [CW-1:0]   mul [6];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cs[i]     = (PW+1)'(s2_cr_ff[2*i]) - (PW+1)'(s2_cr_ff[2*i+1]);
         cs_neg[i] = cs[i][PW];
         cs_pos[i] = !cs[i][PW] && (cs[i] != '0);
      end
      straddle = !((cs_pos[0] && cs_pos[1]) || (cs_neg[0] && cs_neg[1]) ||
                   (cs_pos[2] && cs_pos[3]) || (cs_neg[2] && cs_neg[3]));
      fac[0] = s2_pa_ff;  mul[0] = s2_e1_ff;
      fac[1] = s2_pb_ff;  mul[1] = s2_x3_ff;
      fac[2] = s2_pc_ff;  mul[2] = s2_x1_ff;
      fac[3] = s2_pc_ff;  mul[3] = s2_y4_ff;
      fac[4] = s2_pb_ff;  mul[4] = s2_y2_ff;
      fac[5] = s2_pd_ff;  mul[5] = s2_e2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_hit_ff <= s2_box_ff && straddle;
         s3_den_ff <= DW'(s2_pb_ff) - DW'(s2_pc_ff);
         for (int i = 0; i < 6; i++) begin
            s3_lo_ff[i] <= $signed({1'b0, fac[i][CW-1:0]}) * mul[i];
            s3_hi_ff[i] <= $signed(fac[i][PW-1:CW]) * mul[i];
         end
      end
   end

   // ---------------- stage 4: join partial products ----------------
   logic                 s4_valid_ff;
   logic                 s4_hit_ff;
   logic signed [DW-1:0] s4_den_ff;
   logic signed [TW-1:0] s4_tri_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_hit_ff <= s3_hit_ff;
         s4_den_ff <= s3_den_ff;
         for (int i = 0; i < 6; i++) begin
            s4_tri_ff[i] <= (TW'(s3_hi_ff[i]) <<< CW) + TW'(s3_lo_ff[i]);
         end
      end
   end

   // ---------------- stage 5: numerators, degenerate check ----------------
   logic                 s5_valid_ff;
   logic                 s5_hit_ff;
   logic                 s5_degen_ff;
   logic signed [DW-1:0] s5_den_ff;
   logic signed [NW-1:0] s5_nx_ff, s5_ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_hit_ff   <= s4_hit_ff;
         s5_degen_ff <= s4_hit_ff && (s4_den_ff == '0);
         s5_den_ff   <= s4_den_ff;
         s5_nx_ff    <= NW'(s4_tri_ff[0]) + NW'(s4_tri_ff[1]) - NW'(s4_tri_ff[2]);
         s5_ny_ff    <= NW'(s4_tri_ff[3]) - NW'(s4_tri_ff[4]) - NW'(s4_tri_ff[5]);
      end
   end

   // ---------------- stage 6: magnitudes and quotient signs ----------------
   sip_flags_type      s6_fx_ff, s6_fy_ff;
   logic [NW-1:0]      s6_nx_ff, s6_ny_ff;
   logic [DW-1:0]      s6_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_fx_ff.valid <= 1'b0;
         s6_fy_ff.valid <= 1'b0;
      end else if (en) begin
         s6_fx_ff.valid <= s5_valid_ff;
         s6_fy_ff.valid <= s5_valid_ff;
      end
      if (en) begin
         s6_fx_ff.hit        <= s5_hit_ff;
         s6_fx_ff.degenerate <= s5_degen_ff;
         s6_fx_ff.neg        <= s5_nx_ff[NW-1] ^ s5_den_ff[DW-1];
         s6_fy_ff.hit        <= s5_hit_ff;
         s6_fy_ff.degenerate <= s5_degen_ff;
         // y uses the negated denominator
         s6_fy_ff.neg        <= s5_ny_ff[NW-1] ^ !s5_den_ff[DW-1];
         s6_nx_ff  <= s5_nx_ff[NW-1] ? NW'(-s5_nx_ff) : NW'(s5_nx_ff);
         s6_ny_ff  <= s5_ny_ff[NW-1] ? NW'(-s5_ny_ff) : NW'(s5_ny_ff);
         s6_den_ff <= s5_den_ff[DW-1] ? DW'(-s5_den_ff) : DW'(s5_den_ff);
      end
   end

   // ---------------- divide, one quotient bit per stage ----------------
   sip_flags_type            dx_flags, dy_flags;
   logic [COORD_WIDTH-1:0]   qx, qy;

   sip_divider #(
      .N_WIDTH (NW),
      .D_WIDTH (DW),
      .Q_WIDTH (COORD_WIDTH)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_flags  (s6_fx_ff),
      .in_num    (s6_nx_ff),
      .in_den    (s6_den_ff),
      .out_flags (dx_flags),
      .out_quo   (qx)
   );

   sip_divider #(
      .N_WIDTH (NW),
      .D_WIDTH (DW),
      .Q_WIDTH (COORD_WIDTH)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_flags  (s6_fy_ff),
      .in_num    (s6_ny_ff),
      .in_den    (s6_den_ff),
      .out_flags (dy_flags),
      .out_quo   (qy)
   );

   // ---------------- output register ----------------
   logic                          rsp_valid_ff;
   logic                          rsp_hit_ff;
   logic                          rsp_degen_ff;
   logic signed [COORD_WIDTH-1:0] rsp_x_ff, rsp_y_ff;
   logic                          point_ok;

   assign point_ok = dx_flags.hit && !dx_flags.degenerate;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dx_flags.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff   <= dx_flags.hit;
         rsp_degen_ff <= dx_flags.degenerate;
         rsp_x_ff <= !point_ok ? '0 : (dx_flags.neg ? -qx : qx);
         rsp_y_ff <= !point_ok ? '0 : (dy_flags.neg ? -qy : qy);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_degenerate = rsp_degen_ff;
   assign rsp_cross_x    = rsp_x_ff;
   assign rsp_cross_y    = rsp_y_ff;

   // ---------------- assertions ----------------
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      dx_flags.valid == dy_flags.valid)
      else $error("divider lanes out of step");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> !rsp_degenerate && rsp_cross_x == '0 && rsp_cross_y == '0)
      else $error("miss word carries nonzero fields");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_hit && rsp_cross_x == '0 && rsp_cross_y == '0)
      else $error("degenerate word malformed");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en && s5_valid_ff |=> s5_valid_ff && $stable(s5_den_ff))
      else $error("pipeline moved during stall");

endmodule
